[rtl/arp_pkg.sv]
// Package for the ARP resolver: payload structs, result kinds, FSM states.
// Used by every module in rtl/. No dependencies.
package arp_pkg;

    localparam int unsigned TableEntriesDefault = 16;
    localparam int unsigned QueueDepthDefault   = 16;
    localparam int unsigned PortsDefault        = 4;
    localparam int unsigned MaxFrameLenDefault  = 1600;
    localparam int unsigned MaxResults          = 16;
    localparam int unsigned CfgRegs             = 8;

    localparam logic [47:0] BroadcastMac = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        K_REPLY    = 3'd0,
        K_REQUEST  = 3'd1,
        K_RELEASED = 3'd2,
        K_LOOKUP   = 3'd3,
        K_FULL     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        F_RX_ARP  = 2'd0,
        F_LOOKUP  = 2'd1,
        F_ENQUEUE = 2'd2,
        F_REQUEST = 2'd3
    } t_func;

    localparam logic [1:0]  OpNone    = 2'd0;
    localparam logic [1:0]  OpRequest = 2'd1;
    localparam logic [1:0]  OpReply   = 2'd2;
    localparam logic [15:0] ArpOpRequest = 16'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TSCAN,
        S_QSCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] arp_op;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic [1:0]  port;
        logic [7:0]  packet_handle;
        logic [10:0] pkt_bytes;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  out_port;
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [1:0]  out_op;
        logic [31:0] out_sender_ip;
        logic [31:0] out_target_ip;
        logic [7:0]  out_handle;
        logic [10:0] out_len;
        logic        hit;
        logic        last;
    } t_out_item;

    // Queue entry as stored in the queue memory.
    typedef struct packed {
        logic [31:0] hop_ip;
        logic [1:0]  port;
        logic [7:0]  handle;
        logic [10:0] len;
    } t_qentry;

endpackage

[rtl/arp_table_mem.sv]
// IP-to-MAC table memory: one write port, one registered read port.
// Depends on arp_pkg.
module arp_table_mem #(
    parameter int unsigned Depth = arp_pkg::TableEntriesDefault,
    parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [79:0]      i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [79:0]      o_rdata
);
    import arp_pkg::*;

    logic [79:0] mem [Depth];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

[rtl/arp_queue_mem.sv]
// Pending-packet queue memory: one write port, one registered read port.
// Depends on arp_pkg.
module arp_queue_mem #(
    parameter int unsigned Depth = arp_pkg::QueueDepthDefault,
    parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AddrW-1:0]   i_waddr,
    input  arp_pkg::t_qentry   i_wdata,
    input  logic [AddrW-1:0]   i_raddr,
    output arp_pkg::t_qentry   o_rdata
);
    import arp_pkg::*;

    t_qentry mem [Depth];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

[rtl/arp_resolver_with_pending_queue.sv]
// Top level of the ARP resolver with pending-packet queue.
// Depends on arp_pkg, arp_table_mem and arp_queue_mem.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  command  | i_start, o_busy            | i_item  (t_in_item)
//  result   | o_res_valid (strobe)       | o_res   (t_out_item)
//  config   | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Requests, enqueues, send requests and replies that find the queue empty
// keep o_busy low, so they can follow each other every cycle; their result
// comes in the cycle after the transfer. A lookup reads the table one entry a
// cycle and holds o_busy until its scan ends. A received reply scans the
// queue one entry a cycle, compacting it in place through the queue memory's
// read and write ports, and holds o_busy until the scan ends.
// Reset is synchronous and clears the counts and the controller; memory
// contents are not cleared. Results are strobes and cannot be stalled.
module arp_resolver_with_pending_queue #(
    parameter int unsigned TableEntries = arp_pkg::TableEntriesDefault,
    parameter int unsigned QueueDepth   = arp_pkg::QueueDepthDefault,
    parameter int unsigned Ports        = arp_pkg::PortsDefault,
    parameter int unsigned MaxFrameLen  = arp_pkg::MaxFrameLenDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  arp_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output arp_pkg::t_out_item o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);
    import arp_pkg::*;

    localparam int unsigned TAw = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int unsigned QAw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned TCw = $clog2(TableEntries + 1);
    localparam int unsigned QCw = $clog2(QueueDepth + 1);
    localparam int unsigned RCw = $clog2(MaxResults + 1);
    localparam logic [10:0] LenMax = 11'(MaxFrameLen > 2047 ? 2047 : MaxFrameLen);

    // Configuration registers.
    logic [47:0] r_port_mac [4];
    logic [31:0] r_port_ip  [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_port_mac[k] <= '0;
                r_port_ip[k]  <= '0;
            end
        end else if (i_cfg_valid) begin
            if (!i_cfg_index[2]) begin
                r_port_mac[i_cfg_index[1:0]] <= i_cfg_data;
            end else begin
                r_port_ip[i_cfg_index[1:0]] <= i_cfg_data[31:0];
            end
        end
    end

    // Controller state.
    t_state       r_state, n_state;
    t_in_item     r_item,  n_item;
    logic [TCw-1:0] r_tcnt, n_tcnt;
    logic [QCw-1:0] r_qcnt, n_qcnt;
    logic [TCw-1:0] r_ti,   n_ti;   // read index of table scan
    logic [QCw-1:0] r_ri,   n_ri;   // read index of queue scan
    logic [QCw-1:0] r_wi,   n_wi;   // write index of compaction
    logic [RCw-1:0] r_nrel, n_nrel;
    logic           r_pend, n_pend; // a released result is held back
    t_out_item      r_held, n_held;
    logic           r_vld,  n_vld;
    t_out_item      r_res,  n_res;

    // Memory ports.
    logic            t_we;
    logic [TAw-1:0]  t_waddr, t_raddr;
    logic [79:0]     t_wdata, t_rdata;
    logic            q_we;
    logic [QAw-1:0]  q_waddr, q_raddr;
    t_qentry         q_wdata, q_rdata;

    arp_table_mem #(.Depth(TableEntries), .AddrW(TAw)) u_table (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    arp_queue_mem #(.Depth(QueueDepth), .AddrW(QAw)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tcnt  <= '0;
            r_qcnt  <= '0;
            r_ti    <= '0;
            r_ri    <= '0;
            r_wi    <= '0;
            r_nrel  <= '0;
            r_pend  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tcnt  <= n_tcnt;
            r_qcnt  <= n_qcnt;
            r_ti    <= n_ti;
            r_ri    <= n_ri;
            r_wi    <= n_wi;
            r_nrel  <= n_nrel;
            r_pend  <= n_pend;
            r_vld   <= n_vld;
        end
        r_item <= n_item;
        r_held <= n_held;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_vld;
    assign o_res       = r_res;

    // Next state, memory control and results.
    always_comb begin
        t_out_item o;
        logic      port_ok;
        logic      match;
        logic [1:0] qp;
        o       = '0;
        n_state = r_state;
        n_item  = r_item;
        n_tcnt  = r_tcnt;
        n_qcnt  = r_qcnt;
        n_ti    = r_ti;
        n_ri    = r_ri;
        n_wi    = r_wi;
        n_nrel  = r_nrel;
        n_pend  = r_pend;
        n_held  = r_held;
        n_vld   = 1'b0;
        n_res   = '0;
        t_we    = 1'b0;
        t_waddr = r_tcnt[TAw-1:0];
        t_wdata = {r_item.sender_ip, r_item.sender_mac};
        t_raddr = r_ti[TAw-1:0];
        q_we    = 1'b0;
        q_waddr = r_wi[QAw-1:0];
        q_wdata = q_rdata;
        q_raddr = r_ri[QAw-1:0];
        port_ok = ({30'd0, i_item.port} < 32'(Ports));
        match   = 1'b0;
        qp      = q_rdata.port;

        case (r_state)
            S_IDLE: begin
                n_ti   = '0;
                n_ri   = '0;
                n_wi   = '0;
                n_nrel = '0;
                n_pend = 1'b0;
                t_raddr = '0;
                q_raddr = '0;
                if (i_start) begin
                    n_item = i_item;
                    case (t_func'(i_item.func))
                        F_RX_ARP: begin
                            if (i_item.arp_op != ArpOpRequest) begin
                                if (r_tcnt >= TCw'(TableEntries)) begin
                                    o.kind = K_FULL;
                                    o.last = 1'b1;
                                    n_vld  = 1'b1;
                                    n_res  = o;
                                end else begin
                                    t_we    = 1'b1;
                                    t_wdata = {i_item.sender_ip, i_item.sender_mac};
                                    n_tcnt  = r_tcnt + 1'b1;
                                    n_state = (r_qcnt == '0) ? S_IDLE : S_QSCAN;
                                    n_ri    = (r_qcnt == '0) ? '0 : QCw'(1);
                                end
                            end else if (port_ok &&
                                         r_port_ip[i_item.port] == i_item.target_ip) begin
                                o.kind          = K_REPLY;
                                o.out_port      = i_item.port;
                                o.dest_mac      = i_item.sender_mac;
                                o.src_mac       = r_port_mac[i_item.port];
                                o.out_op        = OpReply;
                                o.out_sender_ip = r_port_ip[i_item.port];
                                o.out_target_ip = i_item.sender_ip;
                                o.last          = 1'b1;
                                n_vld = 1'b1;
                                n_res = o;
                            end
                        end
                        F_LOOKUP: begin
                            if (r_tcnt == '0) begin
                                o.kind = K_LOOKUP;
                                o.last = 1'b1;
                                n_vld  = 1'b1;
                                n_res  = o;
                            end else begin
                                n_state = S_TSCAN;
                                n_ti    = TCw'(1);
                            end
                        end
                        F_ENQUEUE: begin
                            if (port_ok) begin
                                if (r_qcnt >= QCw'(QueueDepth)) begin
                                    o.kind = K_FULL;
                                    o.last = 1'b1;
                                    n_vld  = 1'b1;
                                    n_res  = o;
                                end else begin
                                    q_we    = 1'b1;
                                    q_waddr = r_qcnt[QAw-1:0];
                                    q_wdata.hop_ip = i_item.target_ip;
                                    q_wdata.port   = i_item.port;
                                    q_wdata.handle = i_item.packet_handle;
                                    q_wdata.len    = (i_item.pkt_bytes > LenMax) ?
                                                     LenMax : i_item.pkt_bytes;
                                    n_qcnt = r_qcnt + 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (port_ok) begin
                                o.kind          = K_REQUEST;
                                o.out_port      = i_item.port;
                                o.dest_mac      = BroadcastMac;
                                o.src_mac       = r_port_mac[i_item.port];
                                o.out_op        = OpRequest;
                                o.out_sender_ip = r_port_ip[i_item.port];
                                o.out_target_ip = i_item.target_ip;
                                o.last          = 1'b1;
                                n_vld = 1'b1;
                                n_res = o;
                            end
                        end
                    endcase
                end
            end

            // Table scan: t_rdata holds entry r_ti - 1.
            S_TSCAN: begin
                o.kind = K_LOOKUP;
                o.last = 1'b1;
                if (t_rdata[79:48] == r_item.target_ip) begin
                    o.hit      = 1'b1;
                    o.dest_mac = t_rdata[47:0];
                    n_vld   = 1'b1;
                    n_res   = o;
                    n_state = S_DONE;
                end else if (r_ti >= r_tcnt) begin
                    n_vld   = 1'b1;
                    n_res   = o;
                    n_state = S_DONE;
                end else begin
                    n_ti = r_ti + 1'b1;
                end
            end

            // Queue scan: q_rdata holds entry r_ri - 1. Released entries are held back
            // until the next release or the end of the scan, so the final one can carry last.
            S_QSCAN: begin
                match = (q_rdata.hop_ip == r_item.sender_ip) &&
                        (r_nrel < RCw'(MaxResults));
                if (match) begin
                    qp = q_rdata.port;
                    if (r_pend) begin
                        n_vld = 1'b1;
                        n_res = r_held;
                    end
                    o.kind       = K_RELEASED;
                    o.out_port   = qp;
                    o.dest_mac   = r_item.sender_mac;
                    o.src_mac    = r_port_mac[qp];
                    o.out_handle = q_rdata.handle;
                    o.out_len    = q_rdata.len;
                    n_held = o;
                    n_pend = 1'b1;
                    n_nrel = r_nrel + 1'b1;
                end else begin
                    q_we = 1'b1;
                    n_wi = r_wi + 1'b1;
                end
                if (r_ri >= r_qcnt) begin
                    n_qcnt  = match ? r_wi : r_wi + 1'b1;
                    n_state = S_DONE;
                    if (match) begin
                        n_held.last = 1'b1;
                    end else if (r_pend) begin
                        n_pend = 1'b0;
                        n_vld  = 1'b1;
                        n_res  = r_held;
                        n_res.last = 1'b1;
                    end
                end else begin
                    n_ri = r_ri + 1'b1;
                end
            end

            // Flush a held release if any, then go idle.
            S_DONE: begin
                if (r_pend) begin
                    n_vld  = 1'b1;
                    n_res  = r_held;
                    n_pend = 1'b0;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // Counts never exceed the store depths.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= TCw'(TableEntries) && r_qcnt <= QCw'(QueueDepth))
        else $error("count beyond depth");

    // Compaction never writes ahead of the scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_QSCAN |-> r_wi < r_ri)
        else $error("compaction overtook scan");

    // A result while idle only follows an accepted command or a finished scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(i_start) || $past(r_state) != S_IDLE)
        else $error("spurious result");

    // The queue never grows during a reply scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_QSCAN |=> r_qcnt <= $past(r_qcnt))
        else $error("queue grew during scan");
`endif
endmodule

[tb/arp_resolver_checker.sv]
// Result checker for the ARP resolver: tracks transfers on the command,
// config and result channels, predicts results and compares. Depends on arp_pkg.
module arp_resolver_checker
    import arp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_in_item   i_item,
    input  logic       i_res_valid,
    input  t_out_item  i_res,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output logic       o_accepted
);

    logic [47:0] port_mac [4];
    logic [31:0] port_ip  [4];
    logic [31:0] tbl_ip   [$];
    logic [47:0] tbl_mac  [$];
    t_qentry     waiting  [$];
    t_out_item   expected [$];

    assign o_pending  = expected.size();
    assign o_accepted = (i_start && !i_busy) || i_res_valid || (i_cfg_valid && i_cfg_ready);

    function automatic t_out_item blank_result(t_kind k);
        t_out_item r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        return r;
    endfunction

    // Work out the results of one command and update the shadow state.
    task automatic predict_command(t_in_item it);
        t_out_item r;
        t_qentry   kept [$];
        int        released;
        bit        found;
        logic [10:0] len;
        released = 0;
        found = 0;
        case (t_func'(it.func))
            F_RX_ARP: begin
                if (it.arp_op != ArpOpRequest) begin
                    if (tbl_ip.size() >= 16) begin
                        expected.push_back(blank_result(K_FULL));
                    end else begin
                        tbl_ip.push_back(it.sender_ip);
                        tbl_mac.push_back(it.sender_mac);
                        foreach (waiting[i]) begin
                            if (waiting[i].hop_ip == it.sender_ip && released < MaxResults) begin
                                r = '0;
                                r.kind = K_RELEASED;
                                r.out_port = waiting[i].port;
                                r.dest_mac = it.sender_mac;
                                r.src_mac = port_mac[waiting[i].port];
                                r.out_handle = waiting[i].handle;
                                r.out_len = waiting[i].len;
                                expected.push_back(r);
                                released++;
                            end else begin
                                kept.push_back(waiting[i]);
                            end
                        end
                        waiting = kept;
                        if (released > 0) expected[$].last = 1'b1;
                    end
                end else if (port_ip[it.port] == it.target_ip) begin
                    r = blank_result(K_REPLY);
                    r.out_port = it.port;
                    r.dest_mac = it.sender_mac;
                    r.src_mac = port_mac[it.port];
                    r.out_op = OpReply;
                    r.out_sender_ip = port_ip[it.port];
                    r.out_target_ip = it.sender_ip;
                    expected.push_back(r);
                end
            end
            F_LOOKUP: begin
                r = blank_result(K_LOOKUP);
                foreach (tbl_ip[i]) begin
                    if (!found && tbl_ip[i] == it.target_ip) begin
                        found = 1;
                        r.hit = 1'b1;
                        r.dest_mac = tbl_mac[i];
                    end
                end
                expected.push_back(r);
            end
            F_ENQUEUE: begin
                if (waiting.size() >= 16) begin
                    expected.push_back(blank_result(K_FULL));
                end else begin
                    len = (it.pkt_bytes > 11'd1600) ? 11'd1600 : it.pkt_bytes;
                    waiting.push_back('{it.target_ip, it.port, it.packet_handle, len});
                end
            end
            default: begin
                r = blank_result(K_REQUEST);
                r.out_port = it.port;
                r.dest_mac = BroadcastMac;
                r.src_mac = port_mac[it.port];
                r.out_op = OpRequest;
                r.out_sender_ip = port_ip[it.port];
                r.out_target_ip = it.target_ip;
                expected.push_back(r);
            end
        endcase
    endtask

    // Sample every channel at the clock edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            o_errors <= 0;
            foreach (port_mac[i]) begin
                port_mac[i] = '0;
                port_ip[i] = '0;
            end
            tbl_ip.delete();
            tbl_mac.delete();
            waiting.delete();
            expected.delete();
        end else begin
            if (i_res_valid) begin
                if (expected.size() == 0) begin
                    if (o_errors < 10) $display("Unexpected result %p", i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected.pop_front();
                    if (want !== i_res) begin
                        if (o_errors < 10) $display("Mismatch: expected %p, got %p", want, i_res);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < 4) port_mac[i_cfg_index[1:0]] = i_cfg_data;
                else port_ip[i_cfg_index[1:0]] = i_cfg_data[31:0];
            end
            if (i_start && !i_busy) predict_command(i_item);
        end
    end

endmodule

[tb/tb_arp_resolver_with_pending_queue.sv]
// Testbench top for the ARP resolver: clock, reset, config writes, commands.
// Depends on arp_pkg, the RTL and arp_resolver_checker.
module tb_arp_resolver_with_pending_queue;
    import arp_pkg::*;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       o_busy;
    t_in_item   i_item = '0;
    logic       o_res_valid;
    t_out_item  o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;
    int         errors;
    int         pending;
    logic       accepted;
    int         idle_cycles = 0;
    logic [31:0] ip_pool [4];

    arp_resolver_with_pending_queue u_dut (.*);

    arp_resolver_checker u_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_item, .i_res_valid(o_res_valid),
        .i_res(o_res), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_errors(errors), .o_pending(pending), .o_accepted(accepted)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        idle_cycles <= accepted ? 0 : idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Valid stays high between back-to-back writes; the caller drops it.
    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Wait for every expected result plus the longest scan.
    task automatic drain();
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(bit extreme);
        logic [47:0] mac;
        for (int p = 0; p < 4; p++) begin
            mac = extreme ? (p[0] ? '1 : '0) : 48'({$urandom, $urandom});
            ip_pool[p] = extreme ? (p[1] ? '1 : '0) : $urandom;
            write_reg(3'(p), mac);
            write_reg(3'(p + 4), {16'($urandom), ip_pool[p]});
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Start stays high between back-to-back commands; gaps and drain drop it.
    task automatic send(t_in_item it);
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    function automatic t_in_item make(t_func f, logic [15:0] op, logic [31:0] sip,
                                      logic [31:0] tip, logic [1:0] port);
        t_in_item it;
        it.func = f;
        it.arp_op = op;
        it.sender_ip = sip;
        it.sender_mac = 48'({$urandom, $urandom});
        it.target_ip = tip;
        it.port = port;
        it.packet_handle = 8'($urandom);
        it.pkt_bytes = 11'($urandom);
        return it;
    endfunction

    // Next hops come from a small pool so replies release packets.
    task automatic random_phase(int count);
        t_in_item it;
        logic [31:0] hop;
        int sent = 0;
        int gap;
        while (sent < count) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            for (int b = $urandom_range(1, 8); b > 0 && sent < count; b--) begin
                hop = {28'h0a00000, 4'($urandom_range(0, 5))};
                case ($urandom_range(0, 9))
                    0, 1, 2: it = make(F_ENQUEUE, 16'($urandom), $urandom, hop,
                                       2'($urandom));
                    3, 4: it = make(F_RX_ARP, 16'd2, hop, $urandom, 2'($urandom));
                    5: it = make(F_RX_ARP, ArpOpRequest, $urandom,
                                 $urandom_range(0, 1) ? ip_pool[sent % 4] : $urandom,
                                 2'(sent % 4));
                    6: it = make(F_RX_ARP, 16'($urandom), $urandom, $urandom,
                                 2'($urandom));
                    7, 8: it = make(F_LOOKUP, 16'($urandom), $urandom,
                                    ($urandom_range(0, 3) != 0) ? hop : $urandom,
                                    2'($urandom));
                    default: it = make(F_REQUEST, 16'($urandom), $urandom, $urandom,
                                       2'($urandom));
                endcase
                send(it);
                sent++;
            end
        end
    endtask

    initial begin
        t_in_item it;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        configure(1'b1);

        // Directed: every function, address extremes, a multi-packet release.
        send(make(F_RX_ARP, ArpOpRequest, '1, ip_pool[2], 2'd2));
        send(make(F_RX_ARP, ArpOpRequest, '0, 32'h1234_5678, 2'd1));
        send(make(F_REQUEST, '0, '0, '1, 2'd3));
        send(make(F_LOOKUP, '0, '0, 32'hC0A8_0001, 2'd0));
        for (int i = 0; i < 17; i++) begin
            it = make(F_ENQUEUE, '0, '0, i[0] ? 32'hC0A8_0001 : '1, 2'(i));
            it.pkt_bytes = (i == 1) ? 11'h7FF : (i == 2 ? 11'd0 : 11'd1601);
            it.packet_handle = i[1] ? 8'hFF : 8'h00;
            send(it);
        end
        it = make(F_RX_ARP, 16'hFFFF, 32'hC0A8_0001, '0, 2'd0);
        it.sender_mac = '1;
        send(it);
        send(make(F_LOOKUP, '0, '0, 32'hC0A8_0001, 2'd0));
        send(make(F_RX_ARP, 16'd0, '1, '0, 2'd0));
        drain();

        // Random phases under different port settings; fill the table too.
        configure(1'b0);
        random_phase(50);
        drain();
        configure(1'b0);
        random_phase(40);
        drain();
        for (int i = 0; i < 16; i++) send(make(F_RX_ARP, 16'd2, $urandom, '0, '0));
        drain();
        configure(1'b1);
        random_phase(30);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
